// ===== design/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
// Holds the operation codes, sequencer states and the word-scan helper functions.
// No dependencies.
package bfa_pkg;

    localparam int NUM_WORDS = 32;
    localparam int WORD_BITS = 32;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int BOFF_W    = $clog2(WORD_BITS);
    localparam int POS_W     = WIDX_W + BOFF_W;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WIDX_W-1:0]    widx_t;
    typedef logic [BOFF_W-1:0]    boff_t;
    typedef logic [POS_W-1:0]     pos_t;

    typedef enum logic [2:0] {
        OP_SET_BIT   = 3'd0,
        OP_CLEAR_BIT = 3'd1,
        OP_FIND_BIT  = 3'd2,
        OP_FIND_PAIR = 3'd3,
        OP_CLEAR_ALL = 3'd4,
        OP_READ_WORD = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam widx_t LAST_WORD  = widx_t'(NUM_WORDS - 1);
    localparam boff_t LAST_OFFST = boff_t'(WORD_BITS - 1);

    // Offset (counted from the most significant bit) of the highest set bit.
    function automatic boff_t first_from_msb(input word_t m);
        boff_t off;
        off = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (m[i]) begin
                off = boff_t'(WORD_BITS - 1 - i);
            end
        end
        return off;
    endfunction

    // A bit is set where that map bit and the next lower-numbered-significance
    // bit (the next map position) are both free.
    function automatic word_t pair_mask(input word_t free_bits);
        return {free_bits[WORD_BITS-1:1] & free_bits[WORD_BITS-2:0], 1'b0};
    endfunction

endpackage

// ===== design/bitmap_frame_allocator_unit.sv =====
// Bitmap frame allocator top level: occupancy map, scan sequencer and stream ports.
// Depends on bfa_pkg.
//
// Usage:
// One request beat enters on the s_axis group and produces exactly one response
// beat on the m_axis group. A request sets or clears one map bit, clears the
// whole map, reads one map word, or searches for the lowest free bit or the
// lowest free pair of adjacent bits (a pair may straddle two words).
// Searches only report; they never mark the bit as used.
// Set, clear, clear-all and read pass through the done state to the response
// register; a search first passes through the scan state, since the single word
// examiner walks the map one word per cycle from word 0 and stops at the first
// hit. A new request is taken once the previous one has moved to the output
// register, so a request is not taken before the last one has left the sequencer.
// A response waiting in the output register does not block the next request;
// if the receiver stalls longer, the finished result waits in the sequencer
// and s_axis_tready stays low until the output register frees up.
// Reset clears the whole map to free, empties the output register and returns
// the sequencer to idle.
module bitmap_frame_allocator_unit
    import bfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [12:3] bit_index, [17:13] word_index, [23:18] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [10:1] position, [42:11] word_data, [47:43] zero
    output logic [47:0] m_axis_tdata
);

    word_t  map_reg [NUM_WORDS];

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    widx_t  idx_reg, idx_next;
    logic   prev_free_reg, prev_free_next;
    logic   res_found_reg, res_found_next;
    pos_t   res_pos_reg, res_pos_next;
    word_t  res_data_reg, res_data_next;

    logic   out_valid_reg, out_valid_next;
    logic   out_found_reg, out_found_next;
    pos_t   out_pos_reg, out_pos_next;
    word_t  out_data_reg, out_data_next;

    logic   s_fire;
    logic   m_fire;
    logic   out_load;
    op_t    in_op;
    pos_t   in_bit;
    widx_t  in_word;
    word_t  scan_free;
    word_t  scan_pairs;
    word_t  scan_hits;

    assign in_op   = op_t'(s_axis_tdata[2:0]);
    assign in_bit  = s_axis_tdata[12:3];
    assign in_word = s_axis_tdata[17:13];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg, out_pos_reg, out_found_reg};

    // The one word examiner shared by both searches.
    assign scan_free  = ~map_reg[idx_reg];
    assign scan_pairs = pair_mask(scan_free);
    assign scan_hits  = (op_reg == OP_FIND_PAIR) ? scan_pairs : scan_free;

    // Map storage: single-bit writes and clear-all happen in the request cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                map_reg[w] <= '0;
            end
        end
        else if (s_fire)
        begin
            case (in_op)
                OP_SET_BIT:
                begin
                    map_reg[in_bit[POS_W-1:BOFF_W]][LAST_OFFST - in_bit[BOFF_W-1:0]] <= 1'b1;
                end
                OP_CLEAR_BIT:
                begin
                    map_reg[in_bit[POS_W-1:BOFF_W]][LAST_OFFST - in_bit[BOFF_W-1:0]] <= 1'b0;
                end
                OP_CLEAR_ALL:
                begin
                    for (int w = 0; w < NUM_WORDS; w++)
                    begin
                        map_reg[w] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SET_BIT;
            idx_reg       <= '0;
            prev_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            prev_free_reg <= prev_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_data_reg  <= res_data_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_data_reg  <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        prev_free_next = prev_free_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_data_next  = res_data_reg;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next        = in_op;
                    idx_next       = '0;
                    prev_free_next = 1'b0;
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_data_next  = '0;
                    case (in_op) inside
                        OP_FIND_BIT, OP_FIND_PAIR:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_READ_WORD:
                        begin
                            res_data_next = map_reg[in_word];
                            state_next    = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // A pair that straddles the previous word and this one is the
                // lowest candidate, so it is checked before pairs inside the word.
                if (op_reg == OP_FIND_PAIR && prev_free_reg && scan_free[WORD_BITS-1])
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = {idx_reg - widx_t'(1), LAST_OFFST};
                    state_next     = ST_DONE;
                end
                else if (|scan_hits)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = {idx_reg, first_from_msb(scan_hits)};
                    state_next     = ST_DONE;
                end
                else if (idx_reg == LAST_WORD)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next       = idx_reg + widx_t'(1);
                    prev_free_next = scan_free[0];
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loads a finished result when empty or being drained.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_found_next = res_found_reg;
            out_pos_next   = res_pos_reg;
            out_data_next  = res_data_reg;
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

`ifndef ASSERT_OFF
    // Only one request is in flight, so the port closes right after a beat.
    assert property (@(posedge clk) disable iff (!rst_n) s_fire |=> !s_axis_tready)
        else $error("request taken while another was in flight");

    // A miss or a non-search response carries position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_found_reg) |-> (out_pos_reg == '0))
        else $error("position nonzero without a hit");

    // A search hit never carries word data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_found_reg) |-> (out_data_reg == '0))
        else $error("word data on a search response");

    // Clear-all has emptied the first and last map words by the cycle after the request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_op == OP_CLEAR_ALL) |=>
            (map_reg[0] == '0 && map_reg[NUM_WORDS-1] == '0))
        else $error("map not cleared");
`endif

endmodule
